### src/assert_macros.svh
// Assertion macros used by the checker file rpslr_checker.sv.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/rpslr_pkg.sv
// Types, character codes and expansion tables of the single-line pattern rewriter.
// No dependencies.
package rpslr_pkg;

   localparam int MAX_PATTERN_LENGTH = 4096;
   localparam int COUNT_FIELD_MAX    = 8191;
   localparam int COUNT_W            = 13;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      COUNT_W'((MAX_PATTERN_LENGTH < COUNT_FIELD_MAX) ? MAX_PATTERN_LENGTH : COUNT_FIELD_MAX);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] CH_BSL  = 16'h005C;
   localparam logic [15:0] CH_DOT  = 16'h002E;
   localparam logic [15:0] CH_LBR  = 16'h005B;
   localparam logic [15:0] CH_RBR  = 16'h005D;
   localparam logic [15:0] CH_X    = 16'h0078;
   localparam logic [15:0] CH_ZERO = 16'h0030;
   localparam logic [15:0] CH_S    = 16'h0073;
   localparam logic [15:0] CH_N    = 16'h006E;

   // what the back end emits for one queued item
   typedef enum logic [1:0] {
      KIND_ONE,    // the unit itself
      KIND_PAIR,   // backslash then the unit
      KIND_DOT,    // [^\n]
      KIND_SPACE   // [ \t]
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        char_code;
      logic               last;
      logic               multiline;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic logic [15:0] dot_unit(input logic [2:0] idx);
      logic [15:0] u;
      case (idx)
         3'd0:    u = 16'h005B;
         3'd1:    u = 16'h005E;
         3'd2:    u = 16'h005C;
         3'd3:    u = 16'h006E;
         default: u = 16'h005D;
      endcase
      return u;
   endfunction

   function automatic logic [15:0] space_unit(input logic [2:0] idx);
      logic [15:0] u;
      case (idx)
         3'd0:    u = 16'h005B;
         3'd1:    u = 16'h0020;
         3'd2:    u = 16'h005C;
         3'd3:    u = 16'h0074;
         default: u = 16'h005D;
      endcase
      return u;
   endfunction

endpackage

### src/rpslr_if.sv
// Valid/ready channel interfaces for pattern units in and rewritten units out.
// Depends on rpslr_pkg for the count width.
interface rpslr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] char_code;
   logic [2:0]  chars_after;

   modport source (output valid, output char_code, output chars_after, input ready);
   modport sink   (input valid, input char_code, input chars_after, output ready);
endinterface

interface rpslr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [15:0]                  out_char;
   logic                         run_last;
   logic                         pattern_end;
   logic                         multiline;
   logic [rpslr_pkg::COUNT_W-1:0] replace_count;

   modport source (output valid, output out_char, output run_last, output pattern_end,
                   output multiline, output replace_count, input ready);
   modport sink   (input valid, input out_char, input run_last, input pattern_end,
                   input multiline, input replace_count, output ready);
endinterface

### src/rpslr_front.sv
// Front end: accepts pattern units, tracks class/escape/raw-copy state, and
// classifies each unit into a queue entry. Depends on rpslr_pkg, rpslr_req_if.
module rpslr_front (
   input  logic              clock,
   input  logic              reset,
   rpslr_req_if.sink         req_chan,
   input  logic              q_full,
   output rpslr_pkg::slot_type push
);
   import rpslr_pkg::*;

   logic               in_class_ff, in_class_in;
   logic               esc_ff, esc_in;
   logic [2:0]         raw_left_ff, raw_left_in;
   logic               ml_ff, ml_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   logic               take;
   logic               last;
   logic               emit;
   logic               bump;
   kind_type           kind;
   logic [15:0]        c;

   assign req_chan.ready = !q_full;
   assign take = req_chan.valid && req_chan.ready;
   assign c    = req_chan.char_code;
   assign last = (req_chan.chars_after == 3'd0);

   always_comb begin
      in_class_in = in_class_ff;
      esc_in      = esc_ff;
      raw_left_in = raw_left_ff;
      ml_in       = ml_ff;
      emit        = 1'b1;
      bump        = 1'b0;
      kind        = KIND_ONE;
      if (raw_left_ff != 3'd0) begin
         raw_left_in = raw_left_ff - 3'd1;
      end else if (esc_ff) begin
         esc_in = 1'b0;
         if (c == CH_S) begin
            kind = KIND_SPACE;
            bump = 1'b1;
         end else begin
            kind = KIND_PAIR;
            if (c == CH_X) begin
               ml_in = 1'b1;
               if (req_chan.chars_after >= 3'd4) raw_left_in = 3'd4;
            end else if (c == CH_ZERO) begin
               ml_in = 1'b1;
               if (req_chan.chars_after >= 3'd3) raw_left_in = 3'd3;
            end else if (c == CH_N) begin
               ml_in = 1'b1;
            end
         end
      end else if (c == CH_BSL) begin
         // held until the next unit, unless nothing follows
         if (!last) begin
            esc_in = 1'b1;
            emit   = 1'b0;
         end
      end else if (in_class_ff) begin
         if (c == CH_RBR) in_class_in = 1'b0;
      end else if (c == CH_DOT) begin
         kind = KIND_DOT;
         bump = 1'b1;
      end else if (c == CH_LBR) begin
         in_class_in = 1'b1;
      end
      total_in = (bump && total_ff < COUNT_CAP) ? total_ff + COUNT_W'(1) : total_ff;
   end

   always_comb begin
      push.valid           = take && emit;
      push.entry.kind      = kind;
      push.entry.char_code = c;
      push.entry.last      = last;
      push.entry.multiline = last && ml_in;
      push.entry.count     = last ? total_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_class_ff <= 1'b0;
         esc_ff      <= 1'b0;
         raw_left_ff <= '0;
         ml_ff       <= 1'b0;
         total_ff    <= '0;
      end else if (take) begin
         if (last) begin
            // pattern done: start the next one clean
            in_class_ff <= 1'b0;
            esc_ff      <= 1'b0;
            raw_left_ff <= '0;
            ml_ff       <= 1'b0;
            total_ff    <= '0;
         end else begin
            in_class_ff <= in_class_in;
            esc_ff      <= esc_in;
            raw_left_ff <= raw_left_in;
            ml_ff       <= ml_in;
            total_ff    <= total_in;
         end
      end
   end

endmodule

### src/rpslr_queue.sv
// Short FIFO of classified entries between front and back end.
// Depends on rpslr_pkg.
module rpslr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  rpslr_pkg::slot_type  push,
   input  logic                 pop,
   output logic                 full,
   output rpslr_pkg::slot_type  head
);
   import rpslr_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_pop;

   assign full       = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      fill_in = fill_ff;
      if (push.valid && !do_pop)      fill_in = fill_ff + (QPTR_W+1)'(1);
      else if (!push.valid && do_pop) fill_in = fill_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ptr_ff] <= push.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)     rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         fill_ff <= fill_in;
      end
   end

endmodule

### src/rpslr_back.sv
// Back end: walks each queued entry unit by unit into the output register.
// Depends on rpslr_pkg, rpslr_rsp_if.
module rpslr_back (
   input  logic                clock,
   input  logic                reset,
   input  rpslr_pkg::slot_type head,
   output logic                pop,
   rpslr_rsp_if.source         rsp_chan
);
   import rpslr_pkg::*;

   logic [2:0]         idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [15:0]        char_ff, char_in;
   logic               run_last_ff, end_ff, ml_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [2:0]         len;
   logic               unit_last;
   logic               load;

   always_comb begin
      case (head.entry.kind)
         KIND_ONE:   len = 3'd1;
         KIND_PAIR:  len = 3'd2;
         default:    len = 3'd5;
      endcase
      case (head.entry.kind)
         KIND_ONE:   char_in = head.entry.char_code;
         KIND_PAIR:  char_in = (idx_ff == 3'd0) ? CH_BSL : head.entry.char_code;
         KIND_DOT:   char_in = dot_unit(idx_ff);
         default:    char_in = space_unit(idx_ff);
      endcase
   end

   assign load      = head.valid && (!valid_ff || rsp_chan.ready);
   assign unit_last = (idx_ff == len - 3'd1);
   assign pop       = load && unit_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = unit_last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff     <= char_in;
         run_last_ff <= unit_last;
         end_ff      <= unit_last && head.entry.last;
         ml_ff       <= unit_last && head.entry.multiline;
         count_ff    <= unit_last ? head.entry.count : '0;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.out_char      = char_ff;
   assign rsp_chan.run_last      = run_last_ff;
   assign rsp_chan.pattern_end   = end_ff;
   assign rsp_chan.multiline     = ml_ff;
   assign rsp_chan.replace_count = count_ff;

endmodule

### src/regex_pattern_single_line_rewriter_core.sv
// An accepted unit is queued, then registered at the output as its first rewritten
// unit. One output unit per cycle while ready is high; a unit that expands to five
// ([^\n] or [ \t]) or to a pair holds the back end until its units are out; the
// 4-entry queue absorbs it before input stalls. Input is taken every cycle while
// the queue has room. Synchronous active-high reset clears all pattern state.
module regex_pattern_single_line_rewriter_core (
   input  logic         clock,
   input  logic         reset,
   rpslr_req_if.sink    req_chan,
   rpslr_rsp_if.source  rsp_chan
);
   import rpslr_pkg::*;

   slot_type push;
   slot_type head;
   logic     q_full;
   logic     pop;

   rpslr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   rpslr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   rpslr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### src/rpslr_checker.sv
// Port-level checks of the rewriter output channel, bound to the top level.
// Depends on rpslr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpslr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         run_last,
   input logic                         pattern_end,
   input logic                         multiline,
   input logic [rpslr_pkg::COUNT_W-1:0] replace_count
);
   import rpslr_pkg::*;

   // a result held back must stay offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // the pattern's final unit closes its item's run too
   `ASSERT_ALWAYS(a_end_is_run_last, clock, reset, !rsp_valid || !pattern_end || run_last)
   // flag and count only ride on the final unit
   `ASSERT_ALWAYS(a_summary_quiet, clock, reset,
      !rsp_valid || pattern_end || (!multiline && replace_count == '0))
   `ASSERT_ALWAYS(a_count_capped, clock, reset, !rsp_valid || replace_count <= COUNT_CAP)

endmodule

bind regex_pattern_single_line_rewriter_core rpslr_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .run_last      (rsp_chan.run_last),
   .pattern_end   (rsp_chan.pattern_end),
   .multiline     (rsp_chan.multiline),
   .replace_count (rsp_chan.replace_count)
);
